// ===== sv/uniform_grid_linear_resampler_core_macros.svh =====
// Assertion macros used by the resampler top level.
`ifndef UNIFORM_GRID_LINEAR_RESAMPLER_CORE_MACROS_SVH
`define UNIFORM_GRID_LINEAR_RESAMPLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ULR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ulr: same-cycle check failed");
`define ULR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ulr: next-cycle check failed");
`else
`define ULR_ASSERT_IMPL(name, ante, cons)
`define ULR_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== sv/ulr_pkg.sv =====
// Shared types and constants of the uniform grid linear resampler.
`default_nettype none

package ulr_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int POWER_WIDTH_DEF = 32;

    localparam int IDX_W      = 10;
    localparam int STEP_W     = 20;
    localparam int CNT_W      = 11;
    localparam int POS_W      = 31;
    localparam int OUT_W      = 32;
    localparam int MAG_W      = 33;
    localparam int SUM_W      = 34;
    localparam int PROD_W     = 52;
    localparam int DIV_ITER_W = 6;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_SRC_START = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_STEP  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SRC_COUNT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DST_START = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DST_STEP  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DST_COUNT = 3'd5;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_OOR,
        FIN_END,
        FIN_INTERP
    } fin_t;

    typedef enum logic {
        DIV_BIN,
        DIV_TERM
    } div_sel_t;

    typedef struct packed {
        logic [STEP_W-1:0] src_start;
        logic [STEP_W-1:0] src_step;
        logic [CNT_W-1:0]  src_count;
        logic [STEP_W-1:0] dst_start;
        logic [STEP_W-1:0] dst_step;
        logic [CNT_W-1:0]  dst_count;
    } cfg_t;

    typedef struct packed {
        logic     load;
        logic     take;
        logic     calc_pos;
        logic     div_start;
        div_sel_t div_sel;
        logic     rd_hi;
        logic     cap_a;
        logic     cap_b;
        logic     mul;
        fin_t     fin;
    } cmd_t;

    typedef struct packed {
        logic early_oor;
        logic bin_oor;
        logic bin_end;
        logic div_idle;
    } sts_t;

endpackage

`default_nettype wire

// ===== sv/ulr_apb.sv =====
// APB register file holding the grid configuration.
`default_nettype none

module ulr_apb (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [ulr_pkg::ADDR_W-1:0]  paddr,
    input  wire  [ulr_pkg::DATA_W-1:0]  pwdata,
    output logic [ulr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ulr_pkg::cfg_t               cfg
);
    import ulr_pkg::*;

    logic [STEP_W-1:0]    src_start_reg;
    logic [STEP_W-1:0]    src_step_reg;
    logic [CNT_W-1:0]     src_count_reg;
    logic [STEP_W-1:0]    dst_start_reg;
    logic [STEP_W-1:0]    dst_step_reg;
    logic [CNT_W-1:0]     dst_count_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_start_reg <= '0;
            src_step_reg  <= STEP_W'(256);
            src_count_reg <= CNT_W'(1);
            dst_start_reg <= '0;
            dst_step_reg  <= STEP_W'(256);
            dst_count_reg <= CNT_W'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SRC_START: src_start_reg <= pwdata[STEP_W-1:0];
                REG_SRC_STEP:  src_step_reg  <= pwdata[STEP_W-1:0];
                REG_SRC_COUNT: src_count_reg <= pwdata[CNT_W-1:0];
                REG_DST_START: dst_start_reg <= pwdata[STEP_W-1:0];
                REG_DST_STEP:  dst_step_reg  <= pwdata[STEP_W-1:0];
                REG_DST_COUNT: dst_count_reg <= pwdata[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SRC_START: prdata = DATA_W'(src_start_reg);
            REG_SRC_STEP:  prdata = DATA_W'(src_step_reg);
            REG_SRC_COUNT: prdata = DATA_W'(src_count_reg);
            REG_DST_START: prdata = DATA_W'(dst_start_reg);
            REG_DST_STEP:  prdata = DATA_W'(dst_step_reg);
            REG_DST_COUNT: prdata = DATA_W'(dst_count_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.src_start = src_start_reg;
    assign cfg.src_step  = src_step_reg;
    assign cfg.src_count = src_count_reg;
    assign cfg.dst_start = dst_start_reg;
    assign cfg.dst_step  = dst_step_reg;
    assign cfg.dst_count = dst_count_reg;

endmodule

`default_nettype wire

// ===== sv/ulr_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module ulr_div (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    input  wire  [ulr_pkg::PROD_W-1:0]      dividend,
    input  wire  [ulr_pkg::DIV_ITER_W-1:0]  iters,
    input  wire  [ulr_pkg::STEP_W-1:0]      divisor,
    output logic                            idle,
    output logic [ulr_pkg::PROD_W-1:0]      quotient,
    output logic [ulr_pkg::STEP_W-1:0]      remainder
);
    import ulr_pkg::*;

    logic                  busy_reg;
    logic [DIV_ITER_W-1:0] cnt_reg;
    logic [PROD_W-1:0]     sh_reg;
    logic [STEP_W-1:0]     rem_reg;
    logic [STEP_W:0]       trial;
    logic [STEP_W:0]       sub;
    logic                  ge;

    // dividend is left-aligned by the caller; after iters steps sh_reg holds the quotient
    assign trial = {rem_reg, sh_reg[PROD_W-1]};
    assign sub   = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= iters;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_ITER_W'(1);
            if (cnt_reg == DIV_ITER_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[PROD_W-2:0], ge};
            rem_reg <= ge ? sub[STEP_W-1:0] : trial[STEP_W-1:0];
        end
    end

    assign idle      = !busy_reg;
    assign quotient  = sh_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== sv/ulr_dp.sv =====
// Resampler datapath: sample store, position multiply, divider, interpolation.
`default_nettype none

module ulr_dp #(
    parameter int MAX_SAMPLES = ulr_pkg::MAX_SAMPLES_DEF,
    parameter int POWER_WIDTH = ulr_pkg::POWER_WIDTH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  ulr_pkg::cfg_t                    cfg,
    input  ulr_pkg::cmd_t                    cmd,
    input  wire  [ulr_pkg::IDX_W-1:0]        index,
    input  wire  signed [ulr_pkg::OUT_W-1:0] sample_value,
    output ulr_pkg::sts_t                    sts,
    output logic signed [ulr_pkg::OUT_W-1:0] interp_value,
    output logic                             out_of_range,
    output logic                             last
);
    import ulr_pkg::*;

    localparam int SW = (POWER_WIDTH > OUT_W) ? OUT_W : POWER_WIDTH;
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam logic [31:0] MAX_S32 = 32'(MAX_SAMPLES);
    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (SW - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    function automatic logic [SW-1:0] sat_pw(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI)
        begin
            return SAT_HI[SW-1:0];
        end
        else if (v < SAT_LO)
        begin
            return SAT_LO[SW-1:0];
        end
        return v[SW-1:0];
    endfunction

    logic [SW-1:0]        mem [MAX_SAMPLES];
    logic [SW-1:0]        rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 store_ok;

    logic [IDX_W-1:0]     idx_reg;
    logic                 last_q_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [SW-1:0]        a_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic                 neg_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [OUT_W-1:0]     val_reg;
    logic                 oor_reg;
    logic                 last_reg;

    logic [CNT_W-1:0]     count_eff;
    logic [POS_W-1:0]     src_dist;
    logic [POS_W-1:0]     k;
    logic [POS_W:0]       k_plus1;
    logic [STEP_W-1:0]    rem;
    logic [PROD_W-1:0]    quot;
    logic                 k_ge;
    logic                 k_last;
    logic                 div_idle;
    logic [PROD_W-1:0]    div_dvd;
    logic [DIV_ITER_W-1:0] div_iters;
    logic signed [SUM_W-1:0] diff;
    logic [MAG_W+STEP_W-1:0] prod_full;
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] sum;

    // ---- store ----
    assign store_ok = 32'(index) < MAX_S32;
    assign rd_addr  = cmd.rd_hi ? (AW'(k) + AW'(1)) : AW'(k);

    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
        begin
            mem[AW'(index)] <= sat_pw(SUM_W'(sample_value));
        end
        rd_data_reg <= mem[rd_addr];
    end

    // ---- range checks ----
    assign count_eff = (32'(cfg.src_count) > MAX_S32) ? CNT_W'(MAX_S32) : cfg.src_count;
    assign src_dist  = pos_reg - POS_W'(cfg.src_start);

    assign sts.early_oor = ({1'b0, idx_reg} >= cfg.dst_count)
                        || (pos_reg < POS_W'(cfg.src_start))
                        || (cfg.src_step == '0)
                        || (count_eff == '0);

    assign k       = quot[POS_W-1:0];
    assign k_plus1 = {1'b0, k} + (POS_W+1)'(1);
    assign k_ge    = k >= POS_W'(count_eff);
    assign k_last  = k_plus1 == (POS_W+1)'(count_eff);

    // landing between the last sample and the next grid point is out of range
    assign sts.bin_oor  = k_ge || (k_last && (rem != '0));
    assign sts.bin_end  = k_last && (rem == '0);
    assign sts.div_idle = div_idle;

    // ---- divider, shared by bin search and interpolation term ----
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_BIN:
            begin
                div_dvd   = {src_dist, {(PROD_W-POS_W){1'b0}}};
                div_iters = DIV_ITER_W'(POS_W);
            end
            DIV_TERM:
            begin
                div_dvd   = prod_reg;
                div_iters = DIV_ITER_W'(PROD_W);
            end
            default:
            begin
                div_dvd   = '0;
                div_iters = '0;
            end
        endcase
    end

    ulr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .iters     (div_iters),
        .divisor   (cfg.src_step),
        .idle      (div_idle),
        .quotient  (quot),
        .remainder (rem)
    );

    // ---- interpolation ----
    assign diff      = SUM_W'($signed(rd_data_reg)) - SUM_W'($signed(a_reg));
    assign prod_full = mag_reg * rem;
    assign term      = neg_reg ? -$signed({1'b0, quot[MAG_W-1:0]})
                               : $signed({1'b0, quot[MAG_W-1:0]});
    assign sum       = SUM_W'($signed(a_reg)) + term;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            idx_reg    <= index;
            last_q_reg <= (cfg.dst_count != '0)
                       && ({1'b0, index} == (cfg.dst_count - CNT_W'(1)));
        end
        if (cmd.calc_pos)
        begin
            pos_reg <= POS_W'(cfg.dst_start) + POS_W'(idx_reg * cfg.dst_step);
        end
        if (cmd.cap_a)
        begin
            a_reg <= rd_data_reg;
        end
        if (cmd.cap_b)
        begin
            neg_reg <= diff[SUM_W-1];
            mag_reg <= diff[SUM_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        unique case (cmd.fin)
            FIN_NONE:   ;
            FIN_OOR:
            begin
                val_reg  <= '0;
                oor_reg  <= 1'b1;
                last_reg <= last_q_reg;
            end
            FIN_END:
            begin
                val_reg  <= OUT_W'($signed(rd_data_reg));
                oor_reg  <= 1'b0;
                last_reg <= last_q_reg;
            end
            FIN_INTERP:
            begin
                val_reg  <= OUT_W'($signed(sat_pw(sum)));
                oor_reg  <= 1'b0;
                last_reg <= last_q_reg;
            end
            default:    ;
        endcase
    end

    assign interp_value = $signed(val_reg);
    assign out_of_range = oor_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ===== sv/ulr_ctrl.sv =====
// Resampler controller: sequences each query through the datapath.
`default_nettype none

module ulr_ctrl (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    input  wire            kind,
    input  ulr_pkg::sts_t  sts,
    output ulr_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);
    import ulr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_CHK,
        ST_DIV1,
        ST_BIN,
        ST_END,
        ST_RDA,
        ST_RDB,
        ST_MUL,
        ST_D2S,
        ST_DIV2
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.take   = 1'b1;
                        state_next = ST_POS;
                    end
                end
            end
            ST_POS:
            begin
                cmd.calc_pos = 1'b1;
                state_next   = ST_CHK;
            end
            ST_CHK:
            begin
                if (sts.early_oor)
                begin
                    cmd.fin    = FIN_OOR;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_BIN;
                    state_next    = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (sts.div_idle)
                begin
                    state_next = ST_BIN;
                end
            end
            ST_BIN:
            begin
                // store read of the lower sample is issued here
                if (sts.bin_oor)
                begin
                    cmd.fin    = FIN_OOR;
                    state_next = ST_IDLE;
                end
                else if (sts.bin_end)
                begin
                    state_next = ST_END;
                end
                else
                begin
                    state_next = ST_RDA;
                end
            end
            ST_END:
            begin
                cmd.fin    = FIN_END;
                state_next = ST_IDLE;
            end
            ST_RDA:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_hi  = 1'b1;
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                cmd.cap_b  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_D2S;
            end
            ST_D2S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TERM;
                state_next    = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (sts.div_idle)
                begin
                    cmd.fin    = FIN_INTERP;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (cmd.fin != FIN_NONE);
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== sv/uniform_grid_linear_resampler_core.sv =====
// Top level of the uniform grid linear resampler.
//
//  channel   | ports                                         | beat taken when
//  ----------+-----------------------------------------------+-------------------------------
//  command   | start busy kind index sample_value            | start && !busy
//  result    | done interp_value out_of_range last           | done (one cycle, no stall)
//  config    | psel penable pwrite paddr pwdata prdata pready| psel && penable && pwrite
//
// A load beat writes the store without raising busy, so loads may follow back to back.
// A query holds busy until its result; when it interpolates it makes two passes through the
// bit-serial divider (31 steps for the bin, 52 for the fractional term). Out-of-range queries
// finish at the range check or after the bin pass. The result beat follows busy falling.
// Reset is asynchronous, active low; the store is not cleared and needs no clearing pass.
`default_nettype none

`include "uniform_grid_linear_resampler_core_macros.svh"

module uniform_grid_linear_resampler_core #(
    parameter int MAX_SAMPLES = ulr_pkg::MAX_SAMPLES_DEF,
    parameter int POWER_WIDTH = ulr_pkg::POWER_WIDTH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [ulr_pkg::ADDR_W-1:0]       paddr,
    input  wire  [ulr_pkg::DATA_W-1:0]       pwdata,
    output logic [ulr_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  wire                              start,
    output logic                             busy,
    input  wire                              kind,
    input  wire  [ulr_pkg::IDX_W-1:0]        index,
    input  wire  signed [ulr_pkg::OUT_W-1:0] sample_value,
    output logic                             done,
    output logic signed [ulr_pkg::OUT_W-1:0] interp_value,
    output logic                             out_of_range,
    output logic                             last
);
    import ulr_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    ulr_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ulr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ulr_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .POWER_WIDTH (POWER_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .index        (index),
        .sample_value (sample_value),
        .sts          (sts),
        .interp_value (interp_value),
        .out_of_range (out_of_range),
        .last         (last)
    );

    // a result beat only ever closes a query
    `ULR_ASSERT_IMPL(a_done_after_busy, done, $past(busy))
    `ULR_ASSERT_NEXT(a_done_single, done, !done)
    `ULR_ASSERT_IMPL(a_oor_zero, done && out_of_range, interp_value == '0)
    `ULR_ASSERT_NEXT(a_load_no_busy, start && !busy && (kind == KIND_LOAD), !busy)

endmodule

`default_nettype wire
